// ----- hw/rtl/cor_pkg.sv -----
`default_nettype none
package cor_pkg;

    localparam int SCREEN_BITS  = 13;
    localparam int COLOR_BITS   = 24;
    localparam int STYLE_BITS   = 8;
    localparam int NUM_LANES    = 8;
    localparam int NUM_QUADS    = 4;

    localparam logic [SCREEN_BITS-1:0] RESET_WIDTH  = 13'd1024;
    localparam logic [SCREEN_BITS-1:0] RESET_HEIGHT = 13'd768;

    typedef enum logic {
        KIND_START = 1'b0,
        KIND_STEP  = 1'b1
    } t_kind;

    typedef enum logic {
        CFG_WIDTH  = 1'b0,
        CFG_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef logic [NUM_QUADS-1:0] t_quad_mask;
    typedef logic [NUM_LANES-1:0] t_lane_mask;

    // quadrant set drawn for each style code; unknown codes draw nothing
    function automatic t_quad_mask style_to_mask(input logic [STYLE_BITS-1:0] style);
        t_quad_mask m;
        case (style)
            8'd0:    m = 4'hF;
            8'd1:    m = 4'h1;
            8'd2:    m = 4'h2;
            8'd3:    m = 4'h4;
            8'd4:    m = 4'h8;
            8'd5:    m = 4'h3;
            8'd6:    m = 4'h6;
            8'd7:    m = 4'hC;
            8'd8:    m = 4'h9;
            8'd9:    m = 4'h7;
            8'd10:   m = 4'hE;
            8'd11:   m = 4'hD;
            8'd12:   m = 4'hB;
            default: m = 4'h0;
        endcase
        return m;
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/circle_octant_rasterizer.sv -----
// Midpoint circle rasterizer, one loop iteration per request.
// Input channel (i_in_valid / o_in_ready): a request with i_kind start loads
// centre, radius, style and colour; a request with i_kind step runs one
// iteration and yields the visible pixels among the up to eight octant points.
// Output channel (o_out_valid / i_out_ready): one pixel result per cycle while
// the receiver is ready; o_last_of_step marks the final result of a request.
// Start requests, idle steps and steps with no visible pixel give one result
// with o_pixel_valid 0. The first result of a request passes through the pixel
// serializer and then the output register. A request occupies the serializer
// until it has handed over all its results (1 to 8); the next request is taken
// in the cycle the serializer hands over its last result, so the sustained rate
// is one result per cycle (receiver ready), set by the single output register.
// Screen size is written on the i_cfg_* port (index 0 width, 1 height) by the
// user only while idle, not enforced by the block; reset sets 1024 x 768 and
// clears circle state. Reset is synchronous: no circle active, no result pending.
// When the receiver stalls, the output register holds, the serializer holds
// the rest of the pixels and the input channel drops ready once full.
`default_nettype none
module circle_octant_rasterizer import cor_pkg::*; #(
    parameter int COORD_BITS = 12
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_cfg_we,
    input  wire                      i_cfg_index,
    input  wire  [SCREEN_BITS-1:0]   i_cfg_data,
    input  wire                      i_in_valid,
    output logic                     o_in_ready,
    input  wire                      i_kind,
    input  wire  [COORD_BITS-1:0]    i_center_x,
    input  wire  [COORD_BITS-1:0]    i_center_y,
    input  wire  [COORD_BITS-1:0]    i_radius,
    input  wire  [STYLE_BITS-1:0]    i_style,
    input  wire  [COLOR_BITS-1:0]    i_color,
    output logic                     o_out_valid,
    input  wire                      i_out_ready,
    output logic                     o_pixel_valid,
    output logic [COORD_BITS-1:0]    o_pixel_x,
    output logic [COORD_BITS-1:0]    o_pixel_y,
    output logic [COLOR_BITS-1:0]    o_pixel_color,
    output logic                     o_last_of_step,
    output logic                     o_circle_done
);

    localparam int RW = COORD_BITS + 1;
    localparam int PW = COORD_BITS + 2;
    localparam int EW = COORD_BITS + 3;
    localparam int CW = (RW > SCREEN_BITS) ? RW : SCREEN_BITS;
    localparam int LW = $clog2(NUM_LANES);

    // configuration
    logic [SCREEN_BITS-1:0] r_width, r_height;

    // circle state
    logic                   r_active;
    logic signed [RW-1:0]   r_run_x, r_run_y;
    logic signed [EW-1:0]   r_err;
    logic [COORD_BITS-1:0]  r_ctr_col, r_ctr_row;
    t_quad_mask             r_quad;
    logic [COLOR_BITS-1:0]  r_color;

    // pixel serializer
    logic                   r_wk_busy;
    t_lane_mask             r_wk_mask;
    logic                   r_wk_done;
    logic [COLOR_BITS-1:0]  r_wk_color;
    logic [COORD_BITS-1:0]  r_wk_px [NUM_LANES];
    logic [COORD_BITS-1:0]  r_wk_py [NUM_LANES];

    // output register
    logic                   r_out_valid;
    logic                   r_out_pv;
    logic [COORD_BITS-1:0]  r_out_x, r_out_y;
    logic [COLOR_BITS-1:0]  r_out_color;
    logic                   r_out_last, r_out_done;

    logic                   in_acc, out_free, wk_move, wk_last;
    t_lane_mask             wk_rest;
    logic [LW-1:0]          sel;

    logic signed [PW-1:0]   cx, cy, ex, ey;
    logic signed [PW-1:0]   px [NUM_LANES];
    logic signed [PW-1:0]   py [NUM_LANES];
    t_lane_mask             vis;

    logic signed [EW-1:0]   e1, e2, wx, wy;
    logic signed [RW-1:0]   n_run_x, n_run_y;
    logic                   n_active;

    // --- one midpoint iteration on the current state ---
    always_comb begin
        cx = PW'({2'b00, r_ctr_col});
        cy = PW'({2'b00, r_ctr_row});
        ex = PW'(r_run_x);
        ey = PW'(r_run_y);
        px[0] = cx + ey; py[0] = cy - ex;
        px[1] = cx + ex; py[1] = cy - ey;
        px[2] = cx + ex; py[2] = cy + ey;
        px[3] = cx + ey; py[3] = cy + ex;
        px[4] = cx - ey; py[4] = cy + ex;
        px[5] = cx - ex; py[5] = cy + ey;
        px[6] = cx - ex; py[6] = cy - ey;
        px[7] = cx - ey; py[7] = cy - ex;
        for (int i = 0; i < NUM_LANES; i++) begin
            vis[i] = r_quad[i/2]
                  && !px[i][PW-1] && !px[i][PW-2]
                  && !py[i][PW-1] && !py[i][PW-2]
                  && (CW'(px[i][PW-2:0]) < CW'(r_width))
                  && (CW'(py[i][PW-2:0]) < CW'(r_height));
        end

        n_run_x = r_run_x;
        n_run_y = r_run_y;
        if (r_err <= 0) begin
            n_run_y = r_run_y + RW'(1);
        end
        wy = EW'(n_run_y);
        e1 = (r_err <= 0) ? (r_err + (wy <<< 1) + EW'(1)) : r_err;
        if (e1 > 0) begin
            n_run_x = r_run_x - RW'(1);
        end
        wx = EW'(n_run_x);
        e2 = (e1 > 0) ? (e1 - (wx <<< 1) - EW'(1)) : e1;
        n_active = !(n_run_x < n_run_y);
    end

    // --- handshake ---
    assign out_free = !r_out_valid || i_out_ready;
    assign wk_move  = r_wk_busy && out_free;
    assign wk_rest  = r_wk_mask & (r_wk_mask - t_lane_mask'(1));
    assign wk_last  = (wk_rest == '0);
    assign o_in_ready = !r_wk_busy || (wk_move && wk_last);
    assign in_acc   = i_in_valid && o_in_ready;

    always_comb begin
        sel = '0;
        for (int i = NUM_LANES - 1; i >= 0; i--) begin
            if (r_wk_mask[i]) begin
                sel = LW'(i);
            end
        end
    end

    // --- configuration ---
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= RESET_WIDTH;
            r_height <= RESET_HEIGHT;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_WIDTH:  r_width  <= i_cfg_data;
                CFG_HEIGHT: r_height <= i_cfg_data;
                default:    ;
            endcase
        end
    end

    // --- circle state ---
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= 1'b0;
            r_run_x   <= '0;
            r_run_y   <= '0;
            r_err     <= '0;
            r_ctr_col <= '0;
            r_ctr_row <= '0;
            r_quad    <= '0;
            r_color   <= '0;
        end else if (in_acc) begin
            if (t_kind'(i_kind) == KIND_START) begin
                r_active  <= 1'b1;
                r_run_x   <= RW'({1'b0, i_radius});
                r_run_y   <= '0;
                r_err     <= '0;
                r_ctr_col <= i_center_x;
                r_ctr_row <= i_center_y;
                r_quad    <= style_to_mask(i_style);
                r_color   <= i_color;
            end else if (r_active) begin
                r_active <= n_active;
                r_run_x  <= n_run_x;
                r_run_y  <= n_run_y;
                r_err    <= e2;
            end
        end
    end

    // --- pixel serializer ---
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wk_busy <= 1'b0;
            r_wk_mask <= '0;
        end else if (in_acc) begin
            r_wk_busy <= 1'b1;
            if (t_kind'(i_kind) == KIND_STEP && r_active) begin
                r_wk_mask <= vis;
            end else begin
                r_wk_mask <= '0;
            end
        end else if (wk_move) begin
            r_wk_mask <= wk_rest;
            if (wk_last) begin
                r_wk_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_wk_color <= r_color;
            if (t_kind'(i_kind) == KIND_START) begin
                r_wk_done <= 1'b0;
            end else begin
                r_wk_done <= r_active ? !n_active : 1'b1;
            end
            for (int i = 0; i < NUM_LANES; i++) begin
                r_wk_px[i] <= px[i][COORD_BITS-1:0];
                r_wk_py[i] <= py[i][COORD_BITS-1:0];
            end
        end
    end

    // --- output register ---
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_wk_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wk_move) begin
            r_out_last <= wk_last;
            r_out_done <= r_wk_done;
            if (r_wk_mask != '0) begin
                r_out_pv    <= 1'b1;
                r_out_x     <= r_wk_px[sel];
                r_out_y     <= r_wk_py[sel];
                r_out_color <= r_wk_color;
            end else begin
                r_out_pv    <= 1'b0;
                r_out_x     <= '0;
                r_out_y     <= '0;
                r_out_color <= '0;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_pixel_valid  = r_out_pv;
    assign o_pixel_x      = r_out_x;
    assign o_pixel_y      = r_out_y;
    assign o_pixel_color  = r_out_color;
    assign o_last_of_step = r_out_last;
    assign o_circle_done  = r_out_done;

endmodule
`default_nettype wire
